// ===== design/kmrg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kmrg_pkg;

    localparam int SRC_BITS        = 3;
    localparam int KEY_W           = 64;
    localparam int START_W         = 64;
    localparam int CFG_W           = 4;
    localparam int NUM_SOURCES_DEF = 8;
    localparam int KEY_BITS_DEF    = 64;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    typedef struct packed {
        logic                valid;
        logic [SRC_BITS-1:0] src;
        logic [START_W-1:0]  start;
    } meta_t;

    typedef struct packed {
        logic insert;
        logic emit;
    } ctl_t;

endpackage

`default_nettype wire

// ===== design/kmrg_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kmrg_cell #(
    parameter int KEY_BITS = kmrg_pkg::KEY_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire kmrg_pkg::ctl_t              ctl,
    input  wire logic [kmrg_pkg::CFG_W-1:0]  active_sources,
    input  wire kmrg_pkg::meta_t             new_meta,
    input  wire logic [KEY_BITS-1:0]         new_key,
    input  wire kmrg_pkg::meta_t             left_meta,
    input  wire logic [KEY_BITS-1:0]         left_key,
    input  wire logic                        lt_left,
    input  wire kmrg_pkg::meta_t             right_lp_meta,
    input  wire logic [KEY_BITS-1:0]         right_lp_key,
    input  wire logic                        seen_in,
    output kmrg_pkg::meta_t                  cur_meta,
    output logic [KEY_BITS-1:0]              cur_key,
    output logic                             lt,
    output kmrg_pkg::meta_t                  lp_meta,
    output logic [KEY_BITS-1:0]              lp_key,
    output logic                             lp_elig,
    output logic                             seen_out,
    output logic                             pick
);

    logic                              valid_reg;
    logic [kmrg_pkg::SRC_BITS-1:0]     src_reg;
    logic [kmrg_pkg::START_W-1:0]      start_reg;
    logic [KEY_BITS-1:0]               key_reg;
    kmrg_pkg::meta_t                   meta_next;
    logic [KEY_BITS-1:0]               key_next;
    logic                              rm;

    always_comb
    begin
        cur_meta.valid = valid_reg;
        cur_meta.src   = src_reg;
        cur_meta.start = start_reg;
        cur_key        = key_reg;
    end

    // new record goes ahead of this entry when it orders lower or the slot is empty
    assign lt = ctl.insert &&
                (!valid_reg || ({new_key, new_meta.src} < {key_reg, src_reg}));

    always_comb
    begin
        if (lt_left)
        begin
            lp_meta = left_meta;
            lp_key  = left_key;
        end
        else if (lt)
        begin
            lp_meta = new_meta;
            lp_key  = new_key;
        end
        else
        begin
            lp_meta = cur_meta;
            lp_key  = key_reg;
        end
    end

    assign lp_elig  = lp_meta.valid &&
                      (kmrg_pkg::CFG_W'(lp_meta.src) < active_sources);
    assign seen_out = seen_in || lp_elig;
    assign pick     = lp_elig && !seen_in;
    assign rm       = ctl.emit && seen_out;

    always_comb
    begin
        if (rm)
        begin
            meta_next = right_lp_meta;
            key_next  = right_lp_key;
        end
        else
        begin
            meta_next = lp_meta;
            key_next  = lp_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= meta_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= meta_next.src;
        start_reg <= meta_next.start;
        key_reg   <= key_next;
    end

endmodule

`default_nettype wire

// ===== design/k_way_sorted_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Merges up to NUM_SOURCES ascending record streams into one stream ordered by end key,
// ties going to the lower source index. Heads live in a row of cells kept sorted by
// (end key, source); a transfer from an active, unfinished source with no head inserts
// its record; once every active source holds a head or is finished, a transfer also
// removes the first head of an active source in the same cycle, one record per cycle.
// A result is presented in the output register the cycle after its transfer; the input
// stalls only while it is full and stalled. Reset needs no clearing pass. cfg_wdata sets
// active_sources (reset 8); the user writes it only while idle, which is not enforced.
module k_way_sorted_merge #(
    parameter int NUM_SOURCES = kmrg_pkg::NUM_SOURCES_DEF,
    parameter int KEY_BITS    = kmrg_pkg::KEY_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [kmrg_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [kmrg_pkg::SRC_BITS-1:0]  source,
    input  wire logic [kmrg_pkg::START_W-1:0]   start_key,
    input  wire logic [kmrg_pkg::KEY_W-1:0]     end_key,
    input  wire logic                           source_last,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [kmrg_pkg::SRC_BITS-1:0]       from_source,
    output logic [kmrg_pkg::START_W-1:0]        out_start_key,
    output logic [kmrg_pkg::KEY_W-1:0]          out_end_key,
    output logic                                merge_last
);

    logic [kmrg_pkg::CFG_W-1:0]     active_sources_reg;
    logic [NUM_SOURCES-1:0]         hv_reg;
    logic [NUM_SOURCES-1:0]         hv_mid;
    logic [NUM_SOURCES-1:0]         hv_next;
    logic [NUM_SOURCES-1:0]         fin_reg;
    logic [NUM_SOURCES-1:0]         fin_mid;
    logic [NUM_SOURCES-1:0]         fin_next;
    logic [NUM_SOURCES-1:0]         act;
    logic [NUM_SOURCES-1:0]         src_hot;
    logic [NUM_SOURCES-1:0]         pick_src_hot;
    logic [NUM_SOURCES-1:0]         elig;
    logic [NUM_SOURCES-1:0]         pick;
    logic [NUM_SOURCES-1:0]         lt;
    logic [NUM_SOURCES-1:0]         seen;
    logic [NUM_SOURCES-1:0]         cell_valid;

    kmrg_pkg::meta_t                cur_meta [NUM_SOURCES];
    logic [KEY_BITS-1:0]            cur_key  [NUM_SOURCES];
    kmrg_pkg::meta_t                lp_meta  [NUM_SOURCES];
    logic [KEY_BITS-1:0]            lp_key   [NUM_SOURCES];

    kmrg_pkg::meta_t                new_meta;
    logic [KEY_BITS-1:0]            new_key;
    kmrg_pkg::meta_t                pick_meta;
    logic [KEY_BITS-1:0]            pick_key;
    kmrg_pkg::ctl_t                 ctl;

    logic                           accept;
    logic                           absorb;
    logic                           ready;
    logic                           emit;
    logic                           done;

    logic                           out_valid_reg;
    logic [kmrg_pkg::SRC_BITS-1:0]  from_source_reg;
    logic [kmrg_pkg::START_W-1:0]   out_start_reg;
    logic [KEY_BITS-1:0]            out_key_reg;
    logic                           merge_last_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    genvar g;
    generate
        for (g = 0; g < NUM_SOURCES; g++)
        begin : g_src
            assign act[g]          = 32'(active_sources_reg) > 32'(g);
            assign src_hot[g]      = 32'(source) == 32'(g);
            assign pick_src_hot[g] = 32'(pick_meta.src) == 32'(g);
            assign cell_valid[g]   = cur_meta[g].valid;
        end
    endgenerate

    assign absorb = accept && |(src_hot & act & ~fin_reg & ~hv_reg);

    assign new_meta.valid = 1'b1;
    assign new_meta.src   = source;
    assign new_meta.start = start_key;
    assign new_key        = end_key[KEY_BITS-1:0];

    assign hv_mid  = hv_reg | (absorb ? src_hot : '0);
    assign fin_mid = fin_reg | ((absorb && source_last) ? src_hot : '0);
    assign ready   = &(~act | hv_mid | fin_mid);
    assign emit    = accept && ready && (|elig);
    assign done    = emit && (&(~act | fin_mid)) &&
                     ((elig & (elig - NUM_SOURCES'(1))) == '0);

    assign hv_next  = hv_mid & ~(emit ? pick_src_hot : '0);
    assign fin_next = done ? '0 : fin_mid;

    assign ctl.insert = absorb;
    assign ctl.emit   = emit;

    generate
        for (g = 0; g < NUM_SOURCES; g++)
        begin : g_cell
            kmrg_pkg::meta_t      left_meta;
            logic [KEY_BITS-1:0]  left_key;
            logic                 lt_left;
            kmrg_pkg::meta_t      right_meta;
            logic [KEY_BITS-1:0]  right_key;
            logic                 seen_in;

            if (g == 0)
            begin : g_head
                assign left_meta = '0;
                assign left_key  = '0;
                assign lt_left   = 1'b0;
                assign seen_in   = 1'b0;
            end
            else
            begin : g_body
                assign left_meta = cur_meta[g-1];
                assign left_key  = cur_key[g-1];
                assign lt_left   = lt[g-1];
                assign seen_in   = seen[g-1];
            end

            if (g == NUM_SOURCES - 1)
            begin : g_tail
                assign right_meta = '0;
                assign right_key  = '0;
            end
            else
            begin : g_mid
                assign right_meta = lp_meta[g+1];
                assign right_key  = lp_key[g+1];
            end

            kmrg_cell #(
                .KEY_BITS(KEY_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctl           (ctl),
                .active_sources(active_sources_reg),
                .new_meta      (new_meta),
                .new_key       (new_key),
                .left_meta     (left_meta),
                .left_key      (left_key),
                .lt_left       (lt_left),
                .right_lp_meta (right_meta),
                .right_lp_key  (right_key),
                .seen_in       (seen_in),
                .cur_meta      (cur_meta[g]),
                .cur_key       (cur_key[g]),
                .lt            (lt[g]),
                .lp_meta       (lp_meta[g]),
                .lp_key        (lp_key[g]),
                .lp_elig       (elig[g]),
                .seen_out      (seen[g]),
                .pick          (pick[g])
            );
        end
    endgenerate

    always_comb
    begin
        pick_meta = '0;
        pick_key  = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            pick_meta = pick_meta | (pick[i] ? lp_meta[i] : '0);
            pick_key  = pick_key  | (pick[i] ? lp_key[i]  : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_sources_reg <= kmrg_pkg::ACTIVE_RESET;
            hv_reg             <= '0;
            fin_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_sources_reg <= cfg_wdata;
            end
            if (accept)
            begin
                hv_reg        <= hv_next;
                fin_reg       <= fin_next;
                out_valid_reg <= emit;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            from_source_reg <= pick_meta.src;
            out_start_reg   <= pick_meta.start;
            out_key_reg     <= pick_key;
            merge_last_reg  <= done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign from_source   = from_source_reg;
    assign out_start_key = out_start_reg;
    assign out_end_key   = kmrg_pkg::KEY_W'(out_key_reg);
    assign merge_last    = merge_last_reg;

    a_heads_match_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(hv_reg) == $countones(cell_valid))
        else $error("held head count differs from occupied cells");

    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + NUM_SOURCES'(1))) == '0)
        else $error("occupied cells not packed at the front of the row");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done) |=> (fin_reg == '0) && out_valid_reg && merge_last_reg)
        else $error("end of merge did not clear finished sources");

    a_emit_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> $onehot(pick) && ((hv_mid & pick_src_hot) != '0))
        else $error("emitted record has no held head");

endmodule

`default_nettype wire
